[hdl/qte_pkg.sv]
package qte_pkg;

  // arithmetic widths
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;
  localparam int SQRT_STEPS    = 29;
  localparam int AW            = 34;   // atan2 argument width, Q28
  localparam int XW            = 36;   // cordic vector width
  localparam int ZW            = 35;   // cordic angle width, Q30 radians
  localparam int ZNW           = 36;   // negated angle width
  localparam int SW            = 30;   // clamped arcsine argument
  localparam int RADW          = 57;   // radicand width, Q56
  localparam int RW            = 58;   // square root working width
  localparam int CW            = 29;   // square root result, Q28
  localparam int DW            = 24;   // degree multiplier width
  localparam int PW            = ZNW + DW;
  localparam int VW            = 24;   // scaled angle before saturation

  // pipeline depth from input register to output register
  localparam int LATENCY = 2 + 1 + SQRT_STEPS + 1 + CORDIC_STAGES + 2;
  localparam int CNTW    = $clog2(LATENCY + 1);

  localparam logic signed [ZW-1:0]   PI_Q30  = 35'sd3373259426;
  localparam logic signed [DW-1:0]   DEG_MUL = 24'sd3754936;
  localparam logic signed [AW-1:0]   ONE_Q28 = 34'sd268435456;
  localparam logic [RADW-1:0]        ONE_Q56 = {1'b1, 56'd0};

  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
    32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
    32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128
  };

  // quaternion products carried alongside the square root
  typedef struct packed {
    logic signed [AW-1:0] ry;
    logic signed [AW-1:0] rx;
    logic signed [AW-1:0] yy;
    logic signed [AW-1:0] yx;
    logic signed [SW-1:0] s;
    logic                 clamped;
  } qte_side_t;

  // arctangent of 2^-idx in Q30 radians
  function automatic logic signed [ZW-1:0] atan_q30(input int idx);
    logic signed [ZW-1:0] r;
    r = '0;
    if (idx < ATAN_LEN) r = ZW'($signed({1'b0, ATAN_TAB[idx]}));
    return r;
  endfunction

  // clip to the 16-bit output range
  function automatic logic signed [15:0] sat16(input logic signed [VW-1:0] v);
    logic signed [15:0] r;
    if (v > VW'(32767)) r = 16'sh7fff;
    else if (v < -VW'(32768)) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

[hdl/qte_if.sv]
interface qte_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_real;
  logic signed [15:0] quat_i;
  logic signed [15:0] quat_j;
  logic signed [15:0] quat_k;
  modport source (output valid, quat_real, quat_i, quat_j, quat_k, input ready);
  modport sink   (input valid, quat_real, quat_i, quat_j, quat_k, output ready);
endinterface

interface qte_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  logic               pitch_clamped;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                  input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                  output ready);
endinterface

interface qte_cfg_if;
  logic valid;
  logic ready;
  logic angle_unit;
  modport source (output valid, angle_unit, input ready);
  modport sink   (input valid, angle_unit, output ready);
endinterface

[hdl/qte_prod.sv]
module qte_prod (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [15:0]  q0,
  input  logic signed [15:0]  q1,
  input  logic signed [15:0]  q2,
  input  logic signed [15:0]  q3,
  output logic                out_valid,
  output qte_pkg::qte_side_t  out_side
);

  logic               v1;
  logic signed [31:0] p13, p20, p11, p22, p12, p30, p33, p23, p10;
  logic signed [qte_pkg::AW-1:0] s_raw;
  qte_pkg::qte_side_t side_c;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  // stage 1: component products
  always_ff @(posedge clk) begin
    if (en) begin
      p13 <= q1 * q3;
      p20 <= q2 * q0;
      p11 <= q1 * q1;
      p22 <= q2 * q2;
      p12 <= q1 * q2;
      p30 <= q3 * q0;
      p33 <= q3 * q3;
      p23 <= q2 * q3;
      p10 <= q1 * q0;
    end
  end

  // stage 2: sums and arcsine clamp
  always_comb begin
    side_c.ry = (qte_pkg::AW'(p13) + qte_pkg::AW'(p20)) <<< 1;
    side_c.rx = qte_pkg::ONE_Q28 - ((qte_pkg::AW'(p11) + qte_pkg::AW'(p22)) <<< 1);
    side_c.yy = (qte_pkg::AW'(p12) + qte_pkg::AW'(p30)) <<< 1;
    side_c.yx = qte_pkg::ONE_Q28 - ((qte_pkg::AW'(p22) + qte_pkg::AW'(p33)) <<< 1);
    s_raw     = (qte_pkg::AW'(p23) - qte_pkg::AW'(p10)) <<< 1;
    priority if (s_raw > qte_pkg::ONE_Q28) begin
      side_c.s       = qte_pkg::SW'(qte_pkg::ONE_Q28);
      side_c.clamped = 1'b1;
    end else if (s_raw < -qte_pkg::ONE_Q28) begin
      side_c.s       = -qte_pkg::SW'(qte_pkg::ONE_Q28);
      side_c.clamped = 1'b1;
    end else begin
      side_c.s       = qte_pkg::SW'(s_raw);
      side_c.clamped = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_side <= side_c;
  end

endmodule

[hdl/qte_sqrt.sv]
module qte_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  qte_pkg::qte_side_t        in_side,
  output logic                      out_valid,
  output qte_pkg::qte_side_t        out_side,
  output logic [qte_pkg::CW-1:0]    root
);

  localparam int N = qte_pkg::SQRT_STEPS;

  logic [qte_pkg::RW-1:0] v_q   [N+1];
  logic [qte_pkg::RW-1:0] r_q   [N+1];
  qte_pkg::qte_side_t     side_q[N+1];
  logic                   valid_q [N+1];
  logic signed [2*qte_pkg::SW-1:0] sq;

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= N; k++) valid_q[k] <= 1'b0;
    end else if (en) begin
      valid_q[0] <= in_valid;
      for (int k = 0; k < N; k++) valid_q[k+1] <= valid_q[k];
    end
  end

  // radicand 1 - s^2 in Q56
  assign sq = in_side.s * in_side.s;

  always_ff @(posedge clk) begin
    if (en) begin
      v_q[0]    <= qte_pkg::RW'(qte_pkg::ONE_Q56 - sq[qte_pkg::RADW-1:0]);
      r_q[0]    <= '0;
      side_q[0] <= in_side;
    end
  end

  // one result bit per stage, restoring square root
  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [qte_pkg::RW-1:0] BIT = qte_pkg::RW'(1) << (2 * (N - 1 - k));
    logic [qte_pkg::RW-1:0] trial;
    assign trial = r_q[k] + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[k+1] <= side_q[k];
        if (v_q[k] >= trial) begin
          v_q[k+1] <= v_q[k] - trial;
          r_q[k+1] <= (r_q[k] >> 1) + BIT;
        end else begin
          v_q[k+1] <= v_q[k];
          r_q[k+1] <= r_q[k] >> 1;
        end
      end
    end
  end

  assign out_valid = valid_q[N];
  assign out_side  = side_q[N];
  assign root      = r_q[N][qte_pkg::CW-1:0];

endmodule

[hdl/qte_cordic.sv]
module qte_cordic (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [qte_pkg::AW-1:0]  y_in,
  input  logic signed [qte_pkg::AW-1:0]  x_in,
  input  logic                           tag_in,
  output logic                           out_valid,
  output logic signed [qte_pkg::ZW-1:0]  z_out,
  output logic                           tag_out
);

  localparam int N = qte_pkg::CORDIC_STAGES;

  logic signed [qte_pkg::XW-1:0] x_q [N+1];
  logic signed [qte_pkg::XW-1:0] y_q [N+1];
  logic signed [qte_pkg::ZW-1:0] z_q [N+1];
  logic                          zero_q [N+1];
  logic                          tag_q  [N+1];
  logic                          valid_q [N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= N; k++) valid_q[k] <= 1'b0;
    end else if (en) begin
      valid_q[0] <= in_valid;
      for (int k = 0; k < N; k++) valid_q[k+1] <= valid_q[k];
    end
  end

  // pre-rotation by pi into the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      zero_q[0] <= (x_in == '0) && (y_in == '0);
      tag_q[0]  <= tag_in;
      if (x_in < 0) begin
        x_q[0] <= -qte_pkg::XW'(x_in);
        y_q[0] <= -qte_pkg::XW'(y_in);
        z_q[0] <= (y_in >= 0) ? qte_pkg::PI_Q30 : -qte_pkg::PI_Q30;
      end else begin
        x_q[0] <= qte_pkg::XW'(x_in);
        y_q[0] <= qte_pkg::XW'(y_in);
        z_q[0] <= '0;
      end
    end
  end

  // vectoring iterations
  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic signed [qte_pkg::ZW-1:0] ANG = qte_pkg::atan_q30(i);
    logic signed [qte_pkg::XW-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        zero_q[i+1] <= zero_q[i];
        tag_q[i+1]  <= tag_q[i];
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + ANG;
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - ANG;
        end
      end
    end
  end

  assign out_valid = valid_q[N];
  assign z_out     = zero_q[N] ? '0 : z_q[N];
  assign tag_out   = tag_q[N];

endmodule

[hdl/qte_conv.sv]
module qte_conv (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [qte_pkg::ZW-1:0]  z,
  input  logic                           tag_in,
  input  logic                           negate,
  input  logic                           unit,
  output logic                           out_valid,
  output logic signed [15:0]             angle,
  output logic                           tag_out
);

  logic                           v1;
  logic                           tag1;
  logic signed [qte_pkg::ZNW-1:0] zn_c, zn;
  logic signed [qte_pkg::PW-1:0]  prod;
  logic signed [qte_pkg::ZNW:0]   rad_sum;
  logic signed [qte_pkg::PW:0]    deg_sum;
  logic signed [qte_pkg::VW-1:0]  scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  // stage 1: sign and degree scaling product
  assign zn_c = negate ? -qte_pkg::ZNW'(z) : qte_pkg::ZNW'(z);

  always_ff @(posedge clk) begin
    if (en) begin
      zn   <= zn_c;
      prod <= zn_c * qte_pkg::DEG_MUL;
      tag1 <= tag_in;
    end
  end

  // stage 2: round, shift and saturate
  always_comb begin
    rad_sum = (qte_pkg::ZNW + 1)'(zn) + (qte_pkg::ZNW + 1)'(65536);
    deg_sum = (qte_pkg::PW + 1)'(prod) + ((qte_pkg::PW + 1)'(1) <<< 38);
    if (unit) scaled = qte_pkg::VW'(deg_sum >>> 39);
    else      scaled = qte_pkg::VW'(rad_sum >>> 17);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle   <= qte_pkg::sat16(scaled);
      tag_out <= tag1;
    end
  end

endmodule

[hdl/quaternion_to_euler_angles.sv]
// Quaternion to Euler angles. Takes a signed Q2.14 quaternion on quat and returns
// roll, pitch and yaw on euler, in radians Q3.13 or degrees Q9.7 as cfg selects.
// One quaternion is taken every clock cycle while the pipeline advances; the
// pipeline is two product stages, a one-bit-per-stage square root of 29
// stages plus its squaring stage, the CORDIC pre-rotation and its stages,
// and two unit conversion stages. The whole pipeline advances whenever the
// output register is empty or being taken, so holding euler.ready low stalls
// it without loss. Change angle_unit only while nothing is in flight.
module quaternion_to_euler_angles (
  input  logic          clk,
  input  logic          rst,
  qte_in_if.sink        quat,
  qte_out_if.source     euler,
  qte_cfg_if.sink       cfg
);

  logic                          angle_unit;
  logic                          en;
  logic                          prod_valid, sqrt_valid;
  qte_pkg::qte_side_t            prod_side, sqrt_side;
  logic [qte_pkg::CW-1:0]        root;
  logic                          roll_cv, pitch_cv, yaw_cv;
  logic signed [qte_pkg::ZW-1:0] roll_z, pitch_z, yaw_z;
  logic                          pitch_tag;
  logic                          pitch_ov, yaw_ov;
  logic [qte_pkg::CNTW-1:0]      inflight;

  // configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) angle_unit <= 1'b0;
    else if (cfg.valid) angle_unit <= cfg.angle_unit;
  end

  // global advance
  assign en         = !euler.valid || euler.ready;
  assign quat.ready = en;

  qte_prod u_prod (
    .clk, .rst, .en,
    .in_valid  (quat.valid),
    .q0        (quat.quat_real),
    .q1        (quat.quat_i),
    .q2        (quat.quat_j),
    .q3        (quat.quat_k),
    .out_valid (prod_valid),
    .out_side  (prod_side)
  );

  qte_sqrt u_sqrt (
    .clk, .rst, .en,
    .in_valid  (prod_valid),
    .in_side   (prod_side),
    .out_valid (sqrt_valid),
    .out_side  (sqrt_side),
    .root      (root)
  );

  qte_cordic u_roll_cordic (
    .clk, .rst, .en,
    .in_valid  (sqrt_valid),
    .y_in      (sqrt_side.ry),
    .x_in      (sqrt_side.rx),
    .tag_in    (1'b0),
    .out_valid (roll_cv),
    .z_out     (roll_z),
    .tag_out   ()
  );

  qte_cordic u_pitch_cordic (
    .clk, .rst, .en,
    .in_valid  (sqrt_valid),
    .y_in      (qte_pkg::AW'(sqrt_side.s)),
    .x_in      (qte_pkg::AW'($signed({1'b0, root}))),
    .tag_in    (sqrt_side.clamped),
    .out_valid (pitch_cv),
    .z_out     (pitch_z),
    .tag_out   (pitch_tag)
  );

  qte_cordic u_yaw_cordic (
    .clk, .rst, .en,
    .in_valid  (sqrt_valid),
    .y_in      (sqrt_side.yy),
    .x_in      (sqrt_side.yx),
    .tag_in    (1'b0),
    .out_valid (yaw_cv),
    .z_out     (yaw_z),
    .tag_out   ()
  );

  qte_conv u_roll_conv (
    .clk, .rst, .en,
    .in_valid  (roll_cv),
    .z         (roll_z),
    .tag_in    (1'b0),
    .negate    (1'b1),
    .unit      (angle_unit),
    .out_valid (euler.valid),
    .angle     (euler.roll_angle),
    .tag_out   ()
  );

  qte_conv u_pitch_conv (
    .clk, .rst, .en,
    .in_valid  (pitch_cv),
    .z         (pitch_z),
    .tag_in    (pitch_tag),
    .negate    (1'b0),
    .unit      (angle_unit),
    .out_valid (pitch_ov),
    .angle     (euler.pitch_angle),
    .tag_out   (euler.pitch_clamped)
  );

  qte_conv u_yaw_conv (
    .clk, .rst, .en,
    .in_valid  (yaw_cv),
    .z         (yaw_z),
    .tag_in    (1'b0),
    .negate    (1'b1),
    .unit      (angle_unit),
    .out_valid (yaw_ov),
    .angle     (euler.yaw_angle),
    .tag_out   ()
  );

  // transactions in flight, for checking
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if ((quat.valid && quat.ready) && !(euler.valid && euler.ready)) begin
      inflight <= inflight + 1'b1;
    end else if (!(quat.valid && quat.ready) && (euler.valid && euler.ready)) begin
      inflight <= inflight - 1'b1;
    end
  end

  a_inflight_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= qte_pkg::CNTW'(qte_pkg::LATENCY))
    else $error("more transactions in flight than pipeline stages");

  a_valid_has_source: assert property (@(posedge clk) disable iff (rst)
    euler.valid |-> inflight != '0)
    else $error("result presented with nothing in flight");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (pitch_ov == euler.valid) && (yaw_ov == euler.valid))
    else $error("angle lanes out of step");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    (euler.valid && !angle_unit) |->
      (euler.pitch_angle <= 16'sd12900) && (euler.pitch_angle >= -16'sd12900))
    else $error("pitch outside half turn in radians");

endmodule

[tb/sv/qte_checker.sv]
module qte_checker (
  input  logic clk,
  input  logic rst,
  qte_in_if    quat,
  qte_out_if   euler,
  qte_cfg_if   cfg,
  output int   errors,
  output int   pending
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic               clamped;
  } euler_t;

  euler_t angle_q[$];
  logic   deg_mode;

  // vectoring cordic, angle in q30 radians
  function automatic longint cordic_angle(input longint y_in, input longint x_in);
    longint x, y, z, xs, ys;
    x = x_in;
    y = y_in;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(qte_pkg::PI_Q30) : -longint'(qte_pkg::PI_Q30);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < qte_pkg::CORDIC_STAGES && i < qte_pkg::ATAN_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += longint'(qte_pkg::ATAN_TAB[i]);
      end else begin
        x -= ys; y += xs; z -= longint'(qte_pkg::ATAN_TAB[i]);
      end
    end
    return z;
  endfunction

  // floor integer square root
  function automatic longint unsigned floor_sqrt(input longint unsigned v_in);
    longint unsigned v, r, b;
    v = v_in;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  // q30 radians to output unit with saturation
  function automatic logic signed [15:0] to_unit(input longint z);
    longint v;
    if (deg_mode) v = (z * longint'(qte_pkg::DEG_MUL) + (64'sd1 <<< 38)) >>> 39;
    else v = (z + (64'sd1 <<< 16)) >>> 17;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic euler_t quat_to_euler(input longint q0, input longint q1,
                                           input longint q2, input longint q3);
    longint one, ry, rx, yy, yx, s, c;
    euler_t e;
    one = 64'sd1 <<< 28;
    ry = 2 * (q1 * q3 + q2 * q0);
    rx = one - 2 * (q1 * q1 + q2 * q2);
    yy = 2 * (q1 * q2 + q3 * q0);
    yx = one - 2 * (q2 * q2 + q3 * q3);
    s  = 2 * (q2 * q3 - q1 * q0);
    e.clamped = 1'b0;
    if (s > one) begin s = one; e.clamped = 1'b1; end
    if (s < -one) begin s = -one; e.clamped = 1'b1; end
    c = longint'(floor_sqrt(longint'(64'sd1 <<< 56) - s * s));
    e.roll  = to_unit(-cordic_angle(ry, rx));
    e.pitch = to_unit(cordic_angle(s, c));
    e.yaw   = to_unit(-cordic_angle(yy, yx));
    return e;
  endfunction

  assign pending = angle_q.size();

  // watch all three channels on each edge
  always @(posedge clk) begin
    euler_t want;
    int     nerr;
    nerr = 0;
    if (rst) begin
      deg_mode <= 1'b0;
      errors   <= 0;
      angle_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) deg_mode <= cfg.angle_unit;
      if (quat.valid && quat.ready)
        angle_q.push_back(quat_to_euler(quat.quat_real, quat.quat_i,
                                        quat.quat_j, quat.quat_k));
      if (euler.valid && euler.ready) begin
        if (angle_q.size() == 0) begin
          $error("unexpected euler transaction");
          nerr++;
        end else begin
          want = angle_q.pop_front();
          if (want.roll !== euler.roll_angle) begin
            $error("roll_angle exp %0d got %0d", want.roll, euler.roll_angle);
            nerr++;
          end
          if (want.pitch !== euler.pitch_angle) begin
            $error("pitch_angle exp %0d got %0d", want.pitch, euler.pitch_angle);
            nerr++;
          end
          if (want.yaw !== euler.yaw_angle) begin
            $error("yaw_angle exp %0d got %0d", want.yaw, euler.yaw_angle);
            nerr++;
          end
          if (want.clamped !== euler.pitch_clamped) begin
            $error("pitch_clamped exp %0d got %0d", want.clamped, euler.pitch_clamped);
            nerr++;
          end
        end
      end
      if (nerr != 0) errors <= errors + nerr;
    end
  end
endmodule

[tb/sv/tb_top.sv]
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   pending;
  int   cycles = 0;
  bit   quiet_in = 1'b0;
  bit   quiet_out = 1'b0;
  bit   hold_long = 1'b0;

  qte_in_if  quat ();
  qte_out_if euler ();
  qte_cfg_if cfg ();

  quaternion_to_euler_angles dut (.clk(clk), .rst(rst), .quat(quat), .euler(euler), .cfg(cfg));

  qte_checker chk (.clk(clk), .rst(rst), .quat(quat), .euler(euler), .cfg(cfg),
                   .errors(errors), .pending(pending));

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // offer one quaternion after a random gap, or with no gap when quiet_in is set
  task automatic send_quat(input logic [15:0] r, input logic [15:0] i,
                           input logic [15:0] j, input logic [15:0] k);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      quat.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    quat.valid     <= 1'b1;
    quat.quat_real <= r;
    quat.quat_i    <= i;
    quat.quat_j    <= j;
    quat.quat_k    <= k;
    do @(posedge clk); while (!quat.ready);
  endtask

  // stop sending and wait until every result is back
  task automatic drain;
    quat.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (qte_pkg::LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_unit(input logic unit);
    cfg.valid      <= 1'b1;
    cfg.angle_unit <= unit;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  // random quaternion, mostly near unit length
  task automatic send_random;
    real a, b, c, d, n;
    if ($urandom_range(0, 2) == 0) begin
      send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      a = $urandom_range(0, 20000) - 10000.0;
      b = $urandom_range(0, 20000) - 10000.0;
      c = $urandom_range(0, 20000) - 10000.0;
      d = $urandom_range(0, 20000) - 10000.0;
      n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
      send_quat(16'($rtoi(a / n * 16384.0)) + 16'($urandom_range(0, 6)) - 16'd3,
                16'($rtoi(b / n * 16384.0)), 16'($rtoi(c / n * 16384.0)),
                16'($rtoi(d / n * 16384.0)));
    end
  endtask

  task automatic send_directed;
    send_quat(16'd16384, 16'd0, 16'd0, 16'd0);
    send_quat(16'd0, 16'd0, 16'd0, 16'd0);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    // both arctangent arguments zero
    send_quat(16'd0, 16'd8192, 16'd8192, 16'd0);
    // pitch argument clamped high and low
    send_quat(16'h7fff, 16'h8000, 16'd0, 16'd0);
    send_quat(16'h7fff, 16'h7fff, 16'd0, 16'd0);
    // roll at a quarter turn either way
    send_quat(16'd11585, 16'd0, 16'd11585, 16'd0);
    send_quat(16'd11585, 16'd0, 16'(-11585), 16'd0);
    // negative second argument with both signs of the first
    send_quat(16'd0, 16'd16384, 16'd0, 16'd0);
    send_quat(16'd1000, 16'd16384, 16'd0, 16'd1000);
    send_quat(16'd1000, 16'd16384, 16'd0, 16'(-1000));
    send_quat(16'd0, 16'd0, 16'd16384, 16'd0);
    send_quat(16'd0, 16'd0, 16'd0, 16'd16384);
    send_quat(16'd11585, 16'd11585, 16'd0, 16'd0);
    send_quat(16'd11585, 16'd0, 16'd0, 16'(-11585));
  endtask

  // result side stalls
  initial begin
    int w;
    euler.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_long) begin
        euler.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_long = 1'b0;
      end
      w = quiet_out ? 0 : $urandom_range(0, 15);
      if (w > 0) begin
        euler.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      euler.ready <= 1'b1;
      do @(posedge clk); while (!euler.valid);
    end
  end

  // stimulus
  initial begin
    quat.valid     <= 1'b0;
    quat.quat_real <= '0;
    quat.quat_i    <= '0;
    quat.quat_j    <= '0;
    quat.quat_k    <= '0;
    cfg.valid      <= 1'b0;
    cfg.angle_unit <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_unit(1'b0);
    send_directed();
    drain();
    write_unit(1'b1);
    send_directed();
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_unit(ph[0]);
      quiet_in  = (ph == 1);
      quiet_out = (ph == 2);
      if (ph == 1) hold_long = 1'b1;
      repeat (140) send_random();
      drain();
    end

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
